### rtl/msnr_pkg.sv
// ----------------------------------------------------------------------------
// msnr_pkg: shared types and constants
// Fixed point format, status codes, and the command/status records that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package msnr_pkg;

  // Fraction bits of the signed fixed point format (Q16.16)
  localparam int FRAC_BITS = 16;

  // Half LSB of the product, added before the right shift
  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  // Restoring divider: 96-bit dividend, one quotient bit a cycle
  localparam int DVD_W     = 96;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Quotient magnitude clamp, 2^QCLAMP_BITS
  localparam int QCLAMP_BITS = 40;

  // Final sum width: 32-bit residual plus clamped quotient, with sign
  localparam int TOT_W = QCLAMP_BITS + 2;
  localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'(64'sd2147483647);
  localparam logic signed [TOT_W-1:0] OUT_MIN = TOT_W'(-64'sd2147483648);

  localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;   // capture an input word
    logic mul_item;  // delta * mask
    logic acc;       // round and add into the accumulator
    logic mag;       // take operand magnitudes and result sign
    logic mul_lo;    // |sum|[31:0] * |scale|
    logic mul_hi;    // |sum|[63:32] * |scale|
    logic sum;       // combine partial products into the dividend
    logic div_step;  // one restoring division step
    logic fin_load;  // form the result into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last;      // captured word closes the element
    logic div_zero;  // captured divisor is zero
    logic out_free;  // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

### rtl/masked_sum_normalized_residual.sv
// ----------------------------------------------------------------------------
// masked_sum_normalized_residual: masked weighted sum with residual
// Accumulates rounded delta*mask products per element; on the closing word
// emits residual + scale * sum / divisor, saturated, with a status code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall): one sender word per element
//   member. last_sender closes the element; residual_input and divisor are
//   only looked at on that word.
//   Output channel (result_valid / result_stall): one word per closed
//   element: out_value and status (ok, zero divisor, overflow).
//   Config (cfg_valid / cfg_ready / cfg_data): output gain, always ready;
//   write only while the block is idle.
// Sequence:
//   A non-closing word steps through capture, multiply and accumulate. A
//   closing word goes on through magnitudes, two 32x32 partial products,
//   the dividend sum, the one-bit-a-cycle restoring divider (96 steps) and
//   the output register load. A zero divisor skips the divider and goes from
//   accumulate straight to the output load. The shared multiplier and the
//   divider set this sequence. The result sits in an output register; the
//   block takes new words while it waits. If the receiver still stalls the
//   previous result when the next one is ready, the sequencer holds in its
//   final state.
// Reset (rst, synchronous): clears the accumulator and overflow flag,
//   drops any pending result, and sets the gain to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_sum_normalized_residual (
  input  wire logic               clk,
  input  wire logic               rst,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [31:0] cfg_data,

  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic signed [31:0] delta_value,
  input  wire logic signed [31:0] mask_weight,
  input  wire logic signed [31:0] residual_input,
  input  wire logic signed [31:0] divisor,
  input  wire logic               last_sender,

  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [31:0]      out_value,
  output logic [1:0]              status
);

  msnr_pkg::cmd_t cmd;
  msnr_pkg::sts_t sts;

  // register write never blocks
  assign cfg_ready = 1'b1;

  msnr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  msnr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .delta_value    (delta_value),
    .mask_weight    (mask_weight),
    .residual_input (residual_input),
    .divisor        (divisor),
    .last_sender    (last_sender),
    .out_value      (out_value),
    .status         (status),
    .result_valid   (result_valid),
    .result_stall   (result_stall)
  );

endmodule

`default_nettype wire

### rtl/msnr_dp.sv
// ----------------------------------------------------------------------------
// msnr_dp: datapath
// Input capture, shared multiplier, saturating accumulator, restoring
// divider, final add/saturate and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msnr_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire msnr_pkg::cmd_t      cmd,
  output msnr_pkg::sts_t           sts,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic signed [31:0]  cfg_data,
  input  wire logic signed [31:0]  delta_value,
  input  wire logic signed [31:0]  mask_weight,
  input  wire logic signed [31:0]  residual_input,
  input  wire logic signed [31:0]  divisor,
  input  wire logic                last_sender,
  output logic signed [31:0]       out_value,
  output logic [1:0]               status,
  output logic                     result_valid,
  input  wire logic                result_stall
);

  logic signed [31:0] scale;
  logic signed [31:0] d_reg, m_reg, res_reg, div_reg;
  logic               last_reg;

  logic [63:0]        prod;
  logic [63:0]        lo_prod;
  logic signed [63:0] sum_acc;
  logic               overflow_seen;

  logic [63:0]        a_mag;
  logic [31:0]        b_mag, d_mag;
  logic               neg;

  logic [msnr_pkg::DVD_W-1:0] dvd;
  logic [31:0]                rem;

  // multiplier operands
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] mul_p;

  // accumulate
  logic signed [63:0] rnd, term, sadd, acc_next;
  logic               acc_ovf;

  // divide step
  logic [32:0]        cur, diff;
  logic               ge;

  // final
  logic                                 q_big;
  logic [msnr_pkg::QCLAMP_BITS:0]       qm;
  logic signed [msnr_pkg::TOT_W-1:0]    res_ext, q_ext, total;
  logic                                 sat_hi, sat_lo;
  logic signed [31:0]                   sat_val;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= msnr_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      d_reg    <= delta_value;
      m_reg    <= mask_weight;
      res_reg  <= residual_input;
      div_reg  <= divisor;
      last_reg <= last_sender;
    end
  end

  assign sts.last     = last_reg;
  assign sts.div_zero = (div_reg == 32'sd0);
  assign sts.out_free = !result_valid || !result_stall;

  // one 33x33 signed multiplier: signed item product or unsigned partials
  always_comb begin
    if (cmd.mul_item) begin
      mul_x = {d_reg[31], d_reg};
      mul_y = {m_reg[31], m_reg};
    end else if (cmd.mul_hi) begin
      mul_x = {1'b0, a_mag[63:32]};
      mul_y = {1'b0, b_mag};
    end else begin
      mul_x = {1'b0, a_mag[31:0]};
      mul_y = {1'b0, b_mag};
    end
  end

  assign mul_p = mul_x * mul_y;

  always_ff @(posedge clk) begin
    if (cmd.mul_item || cmd.mul_lo || cmd.mul_hi) begin
      prod <= mul_p[63:0];
    end
    if (cmd.mul_hi) begin
      lo_prod <= prod;
    end
  end

  // round half up, then saturating add
  always_comb begin
    rnd      = $signed(prod) + msnr_pkg::RND_HALF;
    term     = rnd >>> msnr_pkg::FRAC_BITS;
    sadd     = sum_acc + term;
    acc_ovf  = (sum_acc[63] == term[63]) && (sadd[63] != sum_acc[63]);
    acc_next = acc_ovf ? (sum_acc[63] ? msnr_pkg::ACC_MIN : msnr_pkg::ACC_MAX) : sadd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc) begin
      sum_acc       <= acc_next;
      overflow_seen <= overflow_seen | acc_ovf;
    end else if (cmd.fin_load) begin
      sum_acc       <= '0;
      overflow_seen <= 1'b0;
    end
  end

  // magnitudes; negating the most negative value gives 2^(n-1) unsigned
  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      a_mag <= sum_acc[63] ? 64'(-sum_acc) : 64'(sum_acc);
      b_mag <= scale[31] ? 32'(-scale) : 32'(scale);
      d_mag <= div_reg[31] ? 32'(-div_reg) : 32'(div_reg);
      neg   <= sum_acc[63] ^ scale[31] ^ div_reg[31];
    end
  end

  // restoring division, dividend shifts out while quotient shifts in
  always_comb begin
    cur  = {rem, dvd[msnr_pkg::DVD_W-1]};
    diff = cur - {1'b0, d_mag};
    ge   = (cur >= {1'b0, d_mag});
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      dvd <= {32'd0, lo_prod} + {prod, 32'd0};
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[msnr_pkg::DVD_W-2:0], ge};
      rem <= ge ? diff[31:0] : cur[31:0];
    end
  end

  // clamp quotient, apply sign, add residual, saturate
  always_comb begin
    q_big   = (|dvd[msnr_pkg::DVD_W-1:msnr_pkg::QCLAMP_BITS+1])
              || (dvd[msnr_pkg::QCLAMP_BITS] && (|dvd[msnr_pkg::QCLAMP_BITS-1:0]));
    qm      = q_big ? {1'b1, {msnr_pkg::QCLAMP_BITS{1'b0}}} : dvd[msnr_pkg::QCLAMP_BITS:0];
    res_ext = msnr_pkg::TOT_W'(res_reg);
    q_ext   = $signed({1'b0, qm});
    total   = neg ? (res_ext - q_ext) : (res_ext + q_ext);
    sat_hi  = total > msnr_pkg::OUT_MAX;
    sat_lo  = total < msnr_pkg::OUT_MIN;
    if (sat_hi) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (sat_lo) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = total[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      if (sts.div_zero) begin
        out_value <= '0;
        status    <= msnr_pkg::ST_ZERO_DIV;
      end else begin
        out_value <= sat_val;
        status    <= (sat_hi || sat_lo || overflow_seen) ? msnr_pkg::ST_OVERFLOW
                                                         : msnr_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.fin_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_load |=> (sum_acc == 64'sd0) && !overflow_seen)
    else $error("accumulator not cleared after element result");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < d_mag))
    else $error("divider remainder not below divisor");

  a_zero_div_val: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.fin_load) && (status == msnr_pkg::ST_ZERO_DIV) |-> (out_value == 32'sd0))
    else $error("zero divisor result carries nonzero value");
`endif

endmodule

`default_nettype wire

### rtl/msnr_ctrl.sv
// ----------------------------------------------------------------------------
// msnr_ctrl: sequencer
// One-hot state machine stepping one word through multiply, accumulate and,
// on the closing word, the normalize/divide/final sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module msnr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire msnr_pkg::sts_t  sts,
  output msnr_pkg::cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_MUL  = 9'b0_0000_0010,
    S_ACC  = 9'b0_0000_0100,
    S_MAG  = 9'b0_0000_1000,
    S_PLO  = 9'b0_0001_0000,
    S_PHI  = 9'b0_0010_0000,
    S_SUM  = 9'b0_0100_0000,
    S_DIV  = 9'b0_1000_0000,
    S_FIN  = 9'b1_0000_0000
  } state_t;

  state_t                       state, state_next;
  logic [msnr_pkg::DIV_CNT_W-1:0] cnt;
  logic                         cnt_last;

  assign cnt_last   = (cnt == msnr_pkg::DIV_CNT_W'(msnr_pkg::DIV_STEPS - 1));
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_MUL;
      end
      S_MUL: state_next = S_ACC;
      S_ACC: begin
        if (!sts.last)         state_next = S_IDLE;
        else if (sts.div_zero) state_next = S_FIN;
        else                   state_next = S_MAG;
      end
      S_MAG: state_next = S_PLO;
      S_PLO: state_next = S_PHI;
      S_PHI: state_next = S_SUM;
      S_SUM: state_next = S_DIV;
      S_DIV: begin
        if (cnt_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == S_SUM) begin
        cnt <= '0;
      end else if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load_in  = (state == S_IDLE) && item_valid;
    cmd.mul_item = (state == S_MUL);
    cmd.acc      = (state == S_ACC);
    cmd.mag      = (state == S_MAG);
    cmd.mul_lo   = (state == S_PLO);
    cmd.mul_hi   = (state == S_PHI);
    cmd.sum      = (state == S_SUM);
    cmd.div_step = (state == S_DIV);
    cmd.fin_load = (state == S_FIN) && sts.out_free;
  end

`ifndef SYNTHESIS
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_load |-> sts.out_free)
    else $error("result loaded into occupied output register");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && cnt_last |=> (state == S_FIN))
    else $error("divider sequence length wrong");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !sts.out_free |=> (state == S_FIN))
    else $error("result dropped while output blocked");
`endif

endmodule

`default_nettype wire

### sim/tb_masked_sum_normalized_residual.sv
// ----------------------------------------------------------------------------
// tb_masked_sum_normalized_residual: self-checking testbench
// Drives sender words and elements through the input channel and checks each
// element result against a bit-accurate predictor kept in a scoreboard class.
// The run starts with a directed set of corner cases. It then runs random
// element phases under several scale settings and several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_masked_sum_normalized_residual;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int          DRAIN_CYCLES   = 120;   // longer than a closing word
  localparam int          PHASE_WORDS    = 85;
  localparam int          NUM_PHASES     = 8;
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [31:0] QMAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN    = 32'sh8000_0000;
  localparam logic signed [63:0] OUT_HI  = 64'sd2147483647;
  localparam logic signed [63:0] OUT_LO  = -64'sd2147483648;

  // scale per random phase; phase 6 draws a random scale instead
  localparam logic signed [31:0] SCALE_SET [NUM_PHASES] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, -32'sh0001_0000,
    32'sh0001_8000, 32'sh0000_0001, 32'sh0000_0000, 32'sh0001_0000
  };

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         code;
  } elem_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: element reduction predictor plus queue of expected results
  // --------------------------------------------------------------------------
  class residual_checker;
    logic signed [31:0] scale;
    logic signed [63:0] acc;
    bit                 acc_sat;
    elem_result_t       expected_q[$];
    int unsigned        errors;
    int unsigned        checked;

    function new();
      scale   = msnr_pkg::SCALE_RESET;
      acc     = '0;
      acc_sat = 1'b0;
      errors  = 0;
      checked = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("error at %0t: %s", $time, msg);
    endfunction

    // fold one accepted word into the element; close it on last
    function void accumulate_word(logic signed [31:0] d, logic signed [31:0] m,
                                  logic signed [31:0] r, logic signed [31:0] dv,
                                  logic l);
      logic signed [63:0]  dx, mx, prod, term, rx, qs, total;
      logic [64:0]         wide;
      logic signed [127:0] ax, sx, vx;
      logic [127:0]        dividend, quot;
      bit                  neg;
      elem_result_t        e;
      dx   = d;
      mx   = m;
      prod = dx * mx;                          // exact, |prod| <= 2^62
      // round half toward +inf
      term = (prod + msnr_pkg::RND_HALF) >>> msnr_pkg::FRAC_BITS;
      wide = {acc[63], acc} + {term[63], term};
      if (wide[64] != wide[63]) begin
        acc     = wide[64] ? msnr_pkg::ACC_MIN : msnr_pkg::ACC_MAX;
        acc_sat = 1'b1;
      end else begin
        acc = wide[63:0];
      end
      if (!l) return;

      if (dv == 0) begin
        e.value = '0;
        e.code  = msnr_pkg::ST_ZERO_DIV;   // wins over any overflow
      end else begin
        ax       = acc;
        sx       = scale;
        vx       = dv;
        neg      = acc[63] ^ scale[31] ^ dv[31];
        dividend = (ax < 0 ? -ax : ax) * (sx < 0 ? -sx : sx);
        quot     = dividend / (vx < 0 ? -vx : vx);   // truncates toward zero
        if (quot > (128'd1 << msnr_pkg::QCLAMP_BITS))
          quot = 128'd1 << msnr_pkg::QCLAMP_BITS;
        qs       = quot[63:0];
        rx       = r;
        total    = neg ? rx - qs : rx + qs;
        e.code   = msnr_pkg::ST_OK;
        if (total > OUT_HI) begin
          total  = OUT_HI;
          e.code = msnr_pkg::ST_OVERFLOW;
        end else if (total < OUT_LO) begin
          total  = OUT_LO;
          e.code = msnr_pkg::ST_OVERFLOW;
        end
        if (acc_sat) e.code = msnr_pkg::ST_OVERFLOW;
        e.value = total[31:0];
      end
      expected_q.push_back(e);
      acc     = '0;
      acc_sat = 1'b0;
    endfunction

    function void check_result(logic signed [31:0] v, logic [1:0] s);
      elem_result_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with none expected: value %0d status %0d", v, s));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (v !== e.value)
        flag($sformatf("out_value expected %0d (%h) got %0d (%h)", e.value, e.value, v, v));
      if (s !== e.code)
        flag($sformatf("status expected %0d got %0d", e.code, s));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals
  // --------------------------------------------------------------------------
  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_valid      = 1'b0;
  logic               cfg_ready;
  logic signed [31:0] cfg_data       = '0;
  logic               item_valid     = 1'b0;
  logic               item_stall;
  logic signed [31:0] delta_value    = '0;
  logic signed [31:0] mask_weight    = '0;
  logic signed [31:0] residual_input = '0;
  logic signed [31:0] divisor        = '0;
  logic               last_sender    = 1'b0;
  logic               result_valid;
  logic               result_stall   = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         status;

  residual_checker sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     words_sent = 0;
  int unsigned     quiet_cycles = 0;

  masked_sum_normalized_residual i_dut (
    .clk,
    .rst,
    .cfg_valid,
    .cfg_ready,
    .cfg_data,
    .item_valid,
    .item_stall,
    .delta_value,
    .mask_weight,
    .residual_input,
    .divisor,
    .last_sender,
    .result_valid,
    .result_stall,
    .out_value,
    .status
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Q16.16 operand: mostly small values, with a share of extremes and raw words
  function automatic logic signed [31:0] pick_q();
    logic signed [31:0] mag;
    mag = $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 9))
      0:       return QMAX;
      1:       return QMIN;
      2:       return '0;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 1) ? -mag : mag;
    endcase
  endfunction

  // divisor for a closing word; zero shows up about one time in ten
  function automatic logic signed [31:0] pick_div();
    logic signed [31:0] mag;
    mag = $urandom_range(1, 32'h0004_0000);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? QMAX : QMIN;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 1) ? -mag : mag;
    endcase
  endfunction

  // Receiver: stall pattern changes on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= roll(recv_stall_pct);
    end
  end

  // Result words are taken at the rising edge
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(out_value, status);
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("tb_masked_sum_normalized_residual NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers; every task is entered and left just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(logic signed [31:0] d, logic signed [31:0] m,
                           logic signed [31:0] r, logic signed [31:0] dv, logic l);
    while (roll(send_idle_pct)) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid     <= 1'b1;
    delta_value    <= d;
    mask_weight    <= m;
    residual_input <= r;
    divisor        <= dv;
    last_sender    <= l;
    do @(posedge clk); while (item_stall);
    sb.accumulate_word(d, m, r, dv, l);
    words_sent++;
    @(negedge clk);
  endtask

  // Random elements: mostly short, now and then a long one; always ends closed
  task automatic run_elements(int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 20);
      else len = $urandom_range(1, 6);
      for (k = 1; k <= len; k++) begin
        // residual and divisor are junk on non-closing words
        send_item(pick_q(), pick_q(), pick_q(), (k == len) ? pick_div() : $urandom,
                  k == len);
        sent++;
      end
    end
  endtask

  // Wait for all results, then let the datapath settle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_scale(logic signed [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.scale = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic signed [31:0] scale_v;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners, reset scale of 1.0, no idling.
    // Accumulator saturation needs >100k full-scale words; not reachable here.
    send_item(ONE, ONE, 0, ONE, 1'b1);            // plain 1.0 * 1.0
    send_item(1, 32'sd32768, 0, 0, 1'b0);         // exact half rounds up
    send_item(-1, 32'sd32768, 0, 0, 1'b0);        // negative half rounds to zero
    send_item(-1, 32'sd32769, 0, 0, 1'b0);        // just past half, floors to -1
    send_item(3, 32'sd32768, 7, 3, 1'b1);         // truncating divide
    send_item(QMAX, QMAX, 0, 0, 1'b0);
    send_item(QMIN, QMIN, 0, 0, 1'b0);
    send_item(QMIN, QMAX, QMAX, 1, 1'b1);         // positive saturation
    send_item(QMIN, QMAX, QMIN, 1, 1'b1);         // negative saturation
    send_item(5 * ONE, ONE, 0, 0, 1'b1);          // zero divisor
    send_item(3 * ONE, ONE, ONE, -2 * ONE, 1'b1); // negative divisor
    send_item(-1, ONE, 0, 3, 1'b1);               // negative quotient toward zero
    send_item(0, QMIN, QMIN, QMIN, 1'b1);         // empty sum, extreme residual
    send_item(QMAX, ONE, -ONE, QMAX, 1'b1);
    send_item(QMIN, ONE, 0, QMIN, 1'b1);
    send_item(ONE, -ONE, 32'sd12345, 0, 1'b0);    // zero divisor ignored mid-element
    send_item(2 * ONE, ONE, 0, 3 * ONE, 1'b1);
    send_item(QMAX, QMAX, 0, 0, 1'b0);
    send_item(QMAX, QMAX, 0, ONE, 1'b1);          // quotient clamp then saturation
    drain();

    // Random phases: each writes a new scale and picks an idle/stall mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      scale_v = (p == 6) ? $urandom : SCALE_SET[p];
      write_scale(scale_v);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      run_elements(PHASE_WORDS);
      drain();
    end

    $display("ran %0d input words over %0d phases, %0d element results checked",
             words_sent, NUM_PHASES + 1, sb.checked);
    $display("scales covered both 32-bit extremes and zero; idle and stall mixes up to 53%%");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_masked_sum_normalized_residual OK");
    end else begin
      $display("%0d errors, %0d results still outstanding", sb.errors, sb.expected_q.size());
      $display("tb_masked_sum_normalized_residual NOT OK");
    end
    $finish;
  end

endmodule
